// ===== hw/rtl/sac_pkg.sv =====
package sac_pkg;

   localparam int WAYS = 4;
   localparam int MAX_SETS = 256;
   localparam int COUNTER_BITS = 16;
   localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int MAX_SB = $clog2(MAX_SETS);
   localparam int TAG_W = 32;
   // one set row: per way valid, dirty, tag, age, uses
   localparam int ENTRY_W = 2 + TAG_W + 2 * COUNTER_BITS;
   localparam int ROW_W = ENTRY_W * WAYS;
   localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};

   localparam logic [1:0] REG_OFFSET_BITS = 2'd0;
   localparam logic [1:0] REG_SET_BITS = 2'd1;
   localparam logic [1:0] REG_WRITE_BACK = 2'd2;
   localparam logic [1:0] REG_REPLACE_USE = 2'd3;

   typedef struct packed {
      logic [31:0] address;
      logic mode;
   } req_type;

   typedef struct packed {
      logic hit;
      logic [1:0] way_used;
      logic memory_read;
      logic memory_write;
      logic [31:0] hit_total;
      logic [31:0] miss_total;
      logic [31:0] memory_read_total;
      logic [31:0] memory_write_total;
   } rsp_type;

   typedef struct packed {
      logic valid;
      logic dirty;
      logic [TAG_W-1:0] tag;
      logic [COUNTER_BITS-1:0] age;
      logic [COUNTER_BITS-1:0] uses;
   } entry_type;

   typedef struct packed {
      logic [3:0] offset_bits;
      logic [3:0] set_bits;
      logic write_back_mode;
      logic replace_by_use;
   } cfg_type;

   // controller commands to datapath
   typedef struct packed {
      logic capture;
      logic clear_row;
      logic [SET_W-1:0] clear_index;
      logic update;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE = 4'b0010,
      ST_READ = 4'b0100,
      ST_UPDATE = 4'b1000
   } state_type;

endpackage

// ===== hw/rtl/sac_ram.sv =====
module sac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input logic clock,
   input logic wr_en,
   input logic [$clog2(DEPTH)-1:0] wr_addr,
   input logic [WIDTH-1:0] wr_data,
   input logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== hw/rtl/sac_ctrl.sv =====
module sac_ctrl (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   output sac_pkg::cmd_type cmd
);
   sac_pkg::state_type state_ff, state_in;
   logic [sac_pkg::SET_W-1:0] clr_ff, clr_in;

   // sequence clear sweep, then read and update per access
   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      cmd = '0;
      cmd.clear_index = clr_ff;
      case (state_ff)
         sac_pkg::ST_CLEAR: begin
            cmd.clear_row = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == sac_pkg::SET_W'(sac_pkg::MAX_SETS - 1)) begin
               state_in = sac_pkg::ST_IDLE;
            end
         end
         sac_pkg::ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in = sac_pkg::ST_READ;
            end
         end
         sac_pkg::ST_READ: state_in = sac_pkg::ST_UPDATE;
         sac_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in = sac_pkg::ST_IDLE;
         end
         default: state_in = sac_pkg::ST_IDLE;
      endcase
   end

   assign busy = (state_ff != sac_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sac_pkg::ST_CLEAR;
         clr_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
      end
   end
endmodule

// ===== hw/rtl/sac_datapath.sv =====
module sac_datapath (
   input logic clock,
   input logic reset,
   input sac_pkg::cmd_type cmd,
   input sac_pkg::cfg_type cfg,
   input sac_pkg::req_type req,
   output logic rsp_valid,
   output sac_pkg::rsp_type rsp
);
   logic [sac_pkg::SET_W-1:0] set_ff, set_in;
   logic [31:0] tag_ff, tag_in;
   logic wr_ff;
   logic [3:0] sb;
   logic [5:0] shamt;
   logic [31:0] sh_addr;
   logic [sac_pkg::ROW_W-1:0] rd_row, wr_row;
   logic [sac_pkg::SET_W-1:0] wr_addr;
   logic wr_en;
   sac_pkg::entry_type [sac_pkg::WAYS-1:0] row, nrow;
   logic [31:0] hit_ff, miss_ff, mrd_ff, mwr_ff;
   logic hit, found_empty, mread, mwrite;
   logic [sac_pkg::WAY_W-1:0] way, hway, eway, vic;
   logic flag_hit_ff;
   logic [1:0] flag_way_ff;
   logic flag_mread_ff;
   logic flag_mwrite_ff;

   // split the address
   assign sb = (cfg.set_bits > 4'(sac_pkg::MAX_SB)) ? 4'(sac_pkg::MAX_SB) : cfg.set_bits;
   assign shamt = 6'(cfg.offset_bits) + 6'(sb);
   assign sh_addr = req.address >> cfg.offset_bits;
   assign set_in = sac_pkg::SET_W'(sh_addr & ((32'd1 << sb) - 32'd1));
   assign tag_in = 32'(req.address >> shamt);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         set_ff <= set_in;
         tag_ff <= tag_in;
         wr_ff <= req.mode;
      end
   end

   sac_ram #(.WIDTH(sac_pkg::ROW_W), .DEPTH(sac_pkg::MAX_SETS)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_row),
      .rd_addr(set_ff), .rd_data(rd_row)
   );

   assign row = rd_row;

   // compare ways, choose victim, set memory flags and build the updated row
   always_comb begin
      hit = 1'b0;
      hway = '0;
      found_empty = 1'b0;
      eway = '0;
      vic = '0;
      for (int w = sac_pkg::WAYS - 1; w >= 0; w--) begin
         if (row[w].valid && row[w].tag == tag_ff) begin
            hit = 1'b1;
            hway = sac_pkg::WAY_W'(w);
         end
         if (!row[w].valid) begin
            found_empty = 1'b1;
            eway = sac_pkg::WAY_W'(w);
         end
      end
      for (int w = 1; w < sac_pkg::WAYS; w++) begin
         if (cfg.replace_by_use ? (row[w].uses < row[vic].uses)
                                : (row[w].age > row[vic].age)) begin
            vic = sac_pkg::WAY_W'(w);
         end
      end
      way = hit ? hway : (found_empty ? eway : vic);
      mread = !hit && !wr_ff;
      mwrite = (wr_ff && !cfg.write_back_mode) ||
               (!hit && cfg.write_back_mode && row[way].valid && row[way].dirty);
      nrow = row;
      if (hit) begin
         nrow[way].age = '0;
         nrow[way].uses = (row[way].uses == sac_pkg::CNT_MAX) ? row[way].uses
                                                            : row[way].uses + 1'b1;
         if (wr_ff && cfg.write_back_mode) begin
            nrow[way].dirty = 1'b1;
         end
      end else begin
         nrow[way].valid = 1'b1;
         nrow[way].tag = tag_ff;
         nrow[way].age = '0;
         nrow[way].uses = sac_pkg::COUNTER_BITS'(1);
         nrow[way].dirty = wr_ff && cfg.write_back_mode;
      end
      for (int w = 0; w < sac_pkg::WAYS; w++) begin
         if (nrow[w].valid && nrow[w].age != sac_pkg::CNT_MAX) begin
            nrow[w].age = nrow[w].age + 1'b1;
         end
      end
   end

   assign wr_en = cmd.clear_row || cmd.update;
   assign wr_addr = cmd.clear_row ? cmd.clear_index : set_ff;
   assign wr_row = cmd.clear_row ? '0 : sac_pkg::ROW_W'(nrow);

   // advance running totals
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= '0;
         miss_ff <= '0;
         mrd_ff <= '0;
         mwr_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= cmd.update;
         if (cmd.update) begin
            if (hit && hit_ff != '1) hit_ff <= hit_ff + 1'b1;
            if (!hit && miss_ff != '1) miss_ff <= miss_ff + 1'b1;
            if (mread && mrd_ff != '1) mrd_ff <= mrd_ff + 1'b1;
            if (mwrite && mwr_ff != '1) mwr_ff <= mwr_ff + 1'b1;
         end
      end
   end

   // hold flags for the beat
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         flag_hit_ff <= hit;
         flag_way_ff <= 2'(way);
         flag_mread_ff <= mread;
         flag_mwrite_ff <= mwrite;
      end
   end

   assign rsp.hit = flag_hit_ff;
   assign rsp.way_used = flag_way_ff;
   assign rsp.memory_read = flag_mread_ff;
   assign rsp.memory_write = flag_mwrite_ff;
   assign rsp.hit_total = hit_ff;
   assign rsp.miss_total = miss_ff;
   assign rsp.memory_read_total = mrd_ff;
   assign rsp.memory_write_total = mwr_ff;
endmodule

// ===== hw/rtl/set_assoc_cache_tag_controller.sv =====
// channel  ports                               beat taken when
// req      start, busy, req_data               start && !busy
// rsp      rsp_valid, rsp_data                 rsp_valid (one cycle)
// csr      csr_we, csr_index, csr_wdata        csr_we
// An access goes through capture, set row read from the RAM, and row update.
// The next access can be taken in the cycle the result shows; set RAM has one port pair.
// After reset busy stays high while all MAX_SETS (256) rows are cleared.
// The receiver cannot stall; each result shows for one cycle.
module set_assoc_cache_tag_controller (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input sac_pkg::req_type req_data,
   output logic rsp_valid,
   output sac_pkg::rsp_type rsp_data,
   input logic csr_we,
   input logic [1:0] csr_index,
   input logic [3:0] csr_wdata
);
   sac_pkg::cmd_type cmd;
   sac_pkg::cfg_type cfg_ff;

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.offset_bits <= 4'd4;
         cfg_ff.set_bits <= 4'd8;
         cfg_ff.write_back_mode <= 1'b1;
         cfg_ff.replace_by_use <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            sac_pkg::REG_OFFSET_BITS: cfg_ff.offset_bits <= csr_wdata;
            sac_pkg::REG_SET_BITS: cfg_ff.set_bits <= csr_wdata;
            sac_pkg::REG_WRITE_BACK: cfg_ff.write_back_mode <= csr_wdata[0];
            sac_pkg::REG_REPLACE_USE: cfg_ff.replace_by_use <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   sac_ctrl u_ctrl (.clock(clock), .reset(reset), .start(start), .busy(busy), .cmd(cmd));

   sac_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .cfg(cfg_ff), .req(req_data),
      .rsp_valid(rsp_valid), .rsp(rsp_data)
   );

   a_one_hot_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.clear_row, cmd.update}))
      else $error("overlapping commands");
   a_rsp_after_update: assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> rsp_valid)
      else $error("missing result");
   a_capture_to_update: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> ##1 cmd.update)
      else $error("update not issued");
endmodule
